// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the contrast stretch block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When the condition holds, the consequence must hold in the following cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ===== rtl/core/mmcs_pkg.sv =====
// Package with the types and constants of the contrast stretch block.
`default_nettype none
package mmcs_pkg;
    localparam int OP_W   = 2;
    localparam int PIX_W  = 8;
    localparam int NUM_W  = 2 * PIX_W;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] DIV_STEPS = 4'd8;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PULL  = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;

    localparam logic CFG_OUT_LOW  = 1'b0;
    localparam logic CFG_OUT_HIGH = 1'b1;

    localparam logic [PIX_W-1:0] MIN_RESET  = 8'd255;
    localparam logic [PIX_W-1:0] MAX_RESET  = 8'd0;
    localparam logic [PIX_W-1:0] LOW_RESET  = 8'd0;
    localparam logic [PIX_W-1:0] HIGH_RESET = 8'd255;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quot;
        logic             rem_nz;
    } t_div_res;
endpackage
`default_nettype wire

// ===== rtl/core/mmcs_store.sv =====
// Frame store: one write port and one registered read port.
`default_nettype none
module mmcs_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [mmcs_pkg::PIX_W-1:0] i_wdata,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [mmcs_pkg::PIX_W-1:0] o_rdata
);
    import mmcs_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/mmcs_div.sv =====
// Radix-2 restoring divider giving one quotient bit per cycle.
`default_nettype none
module mmcs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [mmcs_pkg::NUM_W-1:0] i_num,
    input  wire logic [mmcs_pkg::PIX_W-1:0] i_den,
    output mmcs_pkg::t_div_res              o_res
);
    import mmcs_pkg::*;

    logic [STEP_W-1:0] r_cnt;
    logic [PIX_W-1:0]  r_rem;
    logic [PIX_W-1:0]  r_lo;
    logic [PIX_W-1:0]  r_den;
    logic              r_done;
    logic [PIX_W:0]    n_trial;
    logic              n_ge;
    logic [PIX_W:0]    n_diff;

    always_comb begin
        n_trial = {r_rem, r_lo[PIX_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_STEPS;
            r_done <= 1'b0;
            r_rem  <= i_num[NUM_W-1:PIX_W];
            r_lo   <= i_num[PIX_W-1:0];
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == STEP_W'(1));
            r_rem  <= n_ge ? n_diff[PIX_W-1:0] : n_trial[PIX_W-1:0];
            r_lo   <= {r_lo[PIX_W-2:0], n_ge};
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quot   = r_lo;
    assign o_res.rem_nz = (r_rem != '0);
endmodule
`default_nettype wire

// ===== rtl/core/min_max_contrast_stretch.sv =====
// Top level of the min-max contrast stretch block: control, statistics and mapping.
// Load and start transactions complete on acceptance; busy stays low for them.
// An accepted pull with a pixel left to read raises busy; its result strobes on o_valid after S_MUL, S_DIVGO, S_DIV.
// A new pull is taken only once busy falls again, after the 8 steps of the radix-2 divider.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Synchronous active-low reset clears the frame statistics and the pointers and sets the levels to low 0, high 255.
`default_nettype none
module min_max_contrast_stretch #(
    parameter int MAX_PIXELS = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [mmcs_pkg::OP_W-1:0]  i_opcode,
    input  wire logic [mmcs_pkg::PIX_W-1:0] i_pixel_in,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [mmcs_pkg::PIX_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic      [mmcs_pkg::PIX_W-1:0] o_pixel_out,
    output logic                            o_frame_last,
    output logic                            o_overflow
);
    import mmcs_pkg::*;

`include "assert_macros.svh"

    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIVGO,
        S_DIV
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [PIX_W-1:0] r_min;
    logic [PIX_W-1:0] r_max;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_rd_ptr;
    logic             r_dropped;
    logic [PIX_W-1:0] r_low;
    logic [PIX_W-1:0] r_high;
    logic [NUM_W-1:0] r_num;
    logic             r_flat;
    logic             r_neg;
    logic             r_last;
    logic             r_ovf;

    logic             n_accept;
    logic             n_full;
    logic             n_can_pull;
    logic             n_load;
    logic             n_pull;
    logic             n_neg;
    logic [PIX_W-1:0] n_mag;
    logic [PIX_W-1:0] n_den;
    logic [PIX_W-1:0] n_offset;
    logic [PIX_W-1:0] n_step;
    logic [PIX_W-1:0] n_result;
    logic [PIX_W-1:0] w_rdata;
    t_div_res         w_div;

    always_comb begin
        n_accept   = start && !busy;
        n_full     = (r_count == CW'(MAX_PIXELS));
        n_can_pull = (r_rd_ptr != r_count);
        n_load     = n_accept && (i_opcode == OP_LOAD) && !n_full;
        n_pull     = n_accept && (i_opcode == OP_PULL) && n_can_pull;
        n_neg      = (r_high < r_low);
        n_mag      = n_neg ? (r_low - r_high) : (r_high - r_low);
        n_den      = r_max - r_min;
        n_offset   = w_rdata - r_min;
        n_step     = w_div.quot + {{(PIX_W-1){1'b0}}, r_neg & w_div.rem_nz};
        if (r_flat) begin
            n_result = r_low;
        end else if (r_neg) begin
            n_result = r_low - n_step;
        end else begin
            n_result = r_low + n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (n_pull) n_state = S_MUL;
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV:   if (w_div.done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    mmcs_store #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_load),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_pixel_in),
        .i_re    (n_pull),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    mmcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_num),
        .i_den   (n_den),
        .o_res   (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_min     <= MIN_RESET;
            r_max     <= MAX_RESET;
            r_count   <= '0;
            r_rd_ptr  <= '0;
            r_dropped <= 1'b0;
            r_low     <= LOW_RESET;
            r_high    <= HIGH_RESET;
            o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OUT_LOW:  r_low  <= i_cfg_data;
                    CFG_OUT_HIGH: r_high <= i_cfg_data;
                    default:      r_low  <= r_low;
                endcase
            end
            if (n_accept) begin
                case (i_opcode)
                    OP_LOAD: begin
                        if (n_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                            if (i_pixel_in < r_min) r_min <= i_pixel_in;
                            if (i_pixel_in > r_max) r_max <= i_pixel_in;
                        end
                    end
                    OP_PULL: begin
                        if (n_can_pull) begin
                            r_rd_ptr <= r_rd_ptr + 1'b1;
                            r_last   <= (r_rd_ptr + 1'b1 == r_count);
                            r_ovf    <= r_dropped;
                        end
                    end
                    OP_START: begin
                        r_min     <= MIN_RESET;
                        r_max     <= MAX_RESET;
                        r_count   <= '0;
                        r_rd_ptr  <= '0;
                        r_dropped <= 1'b0;
                    end
                    default: r_dropped <= r_dropped;
                endcase
            end
            if (r_state == S_MUL) begin
                r_num  <= NUM_W'(n_offset) * NUM_W'(n_mag);
                r_flat <= (r_max == r_min);
                r_neg  <= n_neg;
            end
            if (r_state == S_DIV && w_div.done) begin
                o_valid      <= 1'b1;
                o_pixel_out  <= n_result;
                o_frame_last <= r_last;
                o_overflow   <= r_ovf;
            end
        end
    end

    assign busy = (r_state != S_IDLE);

    `ASSERT_ALWAYS(a_ptr_le_count, r_rd_ptr <= r_count, "read pointer passed the pixel count")
    `ASSERT_ALWAYS(a_min_le_max, (r_count == '0) || (r_min <= r_max), "frame minimum above maximum")
    `ASSERT_ALWAYS(a_valid_after_div, !o_valid || $past(r_state == S_DIV), "result without a division")
    `ASSERT_NEXT(a_pull_busy, n_pull, busy, "accepted pull did not raise busy")
endmodule
`default_nettype wire
